FILE: hw/rtl/wsclk_pkg.sv
// ============================================================================
// wsclk_pkg
// Shared types and constants for the WSClock page replacement block.
// ============================================================================
package wsclk_pkg;

    // Default sizes of the frame ring
    localparam int FRAME_COUNT_DEF = 8;
    localparam int PAGE_BITS_DEF   = 16;
    localparam int TIME_BITS_DEF   = 16;

    // Fixed field widths of the channel words
    localparam int PAGE_W     = 16;
    localparam int TIME_W     = 16;
    localparam int FRAME_IX_W = 3;
    localparam int THR_W      = 16;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_AGE_THRESHOLD = '0;
    localparam logic [THR_W-1:0]      THRESHOLD_RESET   = 16'd5;

    // Input word: one page reference
    typedef struct packed {
        logic [PAGE_W-1:0] page_number;
        logic [TIME_W-1:0] ref_time;
        logic              mark_dirty;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic                  hit;
        logic [FRAME_IX_W-1:0] frame_index;
        logic                  evicted_valid;
        logic [PAGE_W-1:0]     evicted_page;
        logic                  write_back;
    } out_word_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_LOAD
    } wsclk_state_t;

    // Control broadcast to every cell
    typedef struct packed {
        logic hit_upd;   // refresh the matching frame
        logic scan;      // examine the frame under the hand
        logic advance;   // pass the hand token to the next cell
        logic load;      // load the query page into the victim
        logic found;     // a victim was picked during the scan
    } cell_ctl_t;

    // Status returned by each cell
    typedef struct packed {
        logic match;     // valid frame holding the query page
        logic sel;       // this cell is the victim of the load
        logic valid;
        logic dirty;
        logic cand_tok;  // hand is here and the frame qualifies
    } cell_stat_t;

endpackage

FILE: hw/rtl/wsclock_page_replacement.sv
// ============================================================================
// wsclock_page_replacement
// WSClock page replacement over a ring of frame cells with a passed hand.
// ============================================================================
// Flow: on a hit the result word is registered once the output is free; a
// miss goes from lookup to a scan, in which the hand visits 1 to FRAME_COUNT
// frames, and then to a load once the output is free. The hand token moves
// one cell per cycle around the ring; one word is worked on at a time.
// Reset: all frames empty and unreferenced, hand at frame 0, threshold 5.
module wsclock_page_replacement
    import wsclk_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    parameter int PAGE_BITS   = PAGE_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input words
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    // result words
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int FIDX_W = $clog2(FRAME_COUNT);

    wsclk_state_t         state_reg, state_next;
    logic [PAGE_BITS-1:0] q_page_reg;
    logic [TIME_BITS-1:0] q_time_reg;
    logic                 q_dirty_reg;
    logic [FIDX_W-1:0]    cnt_reg;
    logic                 found_reg;
    logic [THR_W-1:0]     thr_reg;
    logic                 m_valid_reg;
    out_word_t            m_data_reg;

    cell_ctl_t            ctl;
    cell_stat_t           stat [FRAME_COUNT];
    logic [PAGE_BITS-1:0] cell_page [FRAME_COUNT];
    logic                 token [FRAME_COUNT];

    logic                 out_free;
    logic                 res_load;
    out_word_t            res_word;
    logic                 last_step;

    logic                 any_match;
    logic                 any_cand;
    logic [FIDX_W-1:0]    hit_idx;
    logic [FIDX_W-1:0]    vic_idx;
    logic                 vic_valid;
    logic                 vic_dirty;
    logic [PAGE_BITS-1:0] vic_page;

    // Ring of frame cells, token passed from each cell to the next
    for (genvar g = 0; g < FRAME_COUNT; g++) begin : g_cell
        wsclk_cell #(
            .PAGE_BITS (PAGE_BITS),
            .TIME_BITS (TIME_BITS),
            .HOME      (g == 0)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .q_page    (q_page_reg),
            .q_time    (q_time_reg),
            .q_dirty   (q_dirty_reg),
            .threshold (thr_reg),
            .token_in  (token[(g + FRAME_COUNT - 1) % FRAME_COUNT]),
            .token_out (token[g]),
            .stat      (stat[g]),
            .page_out  (cell_page[g])
        );
    end

    // Gather cell status; at most one cell matches and one is selected
    always_comb begin
        any_match = 1'b0;
        any_cand  = 1'b0;
        hit_idx   = '0;
        vic_idx   = '0;
        vic_valid = 1'b0;
        vic_dirty = 1'b0;
        vic_page  = '0;
        for (int i = 0; i < FRAME_COUNT; i++) begin
            if (stat[i].match) begin
                any_match = 1'b1;
                hit_idx   = hit_idx | FIDX_W'(i);
            end
            if (stat[i].cand_tok) begin
                any_cand = 1'b1;
            end
            if (stat[i].sel) begin
                vic_idx   = vic_idx | FIDX_W'(i);
                vic_valid = vic_valid | stat[i].valid;
                vic_dirty = vic_dirty | stat[i].dirty;
                vic_page  = vic_page | cell_page[i];
            end
        end
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign last_step = (cnt_reg == FIDX_W'(FRAME_COUNT - 1));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (!any_match) begin
                    state_next = ST_SCAN;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (any_cand || last_step) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Cell control and result word
    always_comb begin
        ctl      = '0;
        res_load = 1'b0;
        res_word = '0;
        ctl.found = found_reg;
        case (state_reg)
            ST_LOOKUP: begin
                if (any_match && out_free) begin
                    ctl.hit_upd          = 1'b1;
                    res_load             = 1'b1;
                    res_word.hit         = 1'b1;
                    res_word.frame_index = FRAME_IX_W'(hit_idx);
                end
            end
            ST_SCAN: begin
                ctl.scan    = 1'b1;
                ctl.advance = 1'b1;
            end
            ST_LOAD: begin
                if (out_free) begin
                    ctl.load               = 1'b1;
                    ctl.advance            = !found_reg;
                    res_load               = 1'b1;
                    res_word.frame_index   = FRAME_IX_W'(vic_idx);
                    res_word.evicted_valid = vic_valid;
                    res_word.evicted_page  = vic_valid ? PAGE_W'(vic_page) : '0;
                    res_word.write_back    = vic_valid && vic_dirty;
                end
            end
            default: begin
                ctl.found = found_reg;
            end
        endcase
    end

    // Sequencer, scan count and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_LOOKUP: begin
                    cnt_reg   <= '0;
                    found_reg <= 1'b0;
                end
                ST_SCAN: begin
                    cnt_reg   <= cnt_reg + 1'b1;
                    found_reg <= any_cand;
                end
                default: begin
                    cnt_reg <= cnt_reg;
                end
            endcase
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the query word and the result word
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            q_page_reg  <= PAGE_BITS'(s_data.page_number);
            q_time_reg  <= TIME_BITS'(s_data.ref_time);
            q_dirty_reg <= s_data.mark_dirty;
        end
        if (res_load) begin
            m_data_reg <= res_word;
        end
    end

    // Threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THRESHOLD_RESET;
        end else if (psel && penable && pwrite
                     && paddr[APB_ADDR_W-1:2] == REG_AGE_THRESHOLD) begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    assign prdata  = (paddr[APB_ADDR_W-1:2] == REG_AGE_THRESHOLD)
                     ? APB_DATA_W'(thr_reg) : '0;
    assign pready  = 1'b1;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: hw/rtl/wsclk_cell.sv
// ============================================================================
// wsclk_cell
// One frame of the ring: page tag, flags, last-use time and hand token.
// ============================================================================
module wsclk_cell
    import wsclk_pkg::*;
#(
    parameter int  PAGE_BITS = PAGE_BITS_DEF,
    parameter int  TIME_BITS = TIME_BITS_DEF,
    parameter bit  HOME      = 1'b0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cell_ctl_t            ctl,
    input  logic [PAGE_BITS-1:0] q_page,
    input  logic [TIME_BITS-1:0] q_time,
    input  logic                 q_dirty,
    input  logic [THR_W-1:0]     threshold,
    input  logic                 token_in,
    output logic                 token_out,
    output cell_stat_t           stat,
    output logic [PAGE_BITS-1:0] page_out
);

    localparam int CMP_W = (TIME_BITS > THR_W) ? TIME_BITS : THR_W;

    logic [PAGE_BITS-1:0] page_reg;
    logic                 valid_reg;
    logic                 ref_reg;
    logic                 dirty_reg;
    logic [TIME_BITS-1:0] last_use_reg;
    logic                 token_reg;
    logic                 pick_reg;

    logic [TIME_BITS-1:0] age;
    logic                 cand;
    logic                 match;
    logic                 sel;

    // Wrapping age and replacement test
    assign age   = q_time - last_use_reg;
    assign cand  = !ref_reg && (CMP_W'(age) > CMP_W'(threshold));
    assign match = valid_reg && (page_reg == q_page);
    assign sel   = pick_reg || (!ctl.found && token_reg);

    // Frame flags, last use and hand token
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            ref_reg      <= 1'b0;
            dirty_reg    <= 1'b0;
            last_use_reg <= '0;
            token_reg    <= HOME;
            pick_reg     <= 1'b0;
        end else begin
            if (ctl.hit_upd && match) begin
                ref_reg      <= 1'b1;
                last_use_reg <= q_time;
            end
            if (ctl.scan && token_reg) begin
                if (cand) begin
                    pick_reg <= 1'b1;
                end else begin
                    ref_reg <= 1'b0;
                end
            end
            if (ctl.load) begin
                pick_reg <= 1'b0;
                if (sel) begin
                    valid_reg    <= 1'b1;
                    ref_reg      <= 1'b1;
                    dirty_reg    <= q_dirty;
                    last_use_reg <= q_time;
                end
            end
            if (ctl.advance) begin
                token_reg <= token_in;
            end
        end
    end

    // Page tag holds no reset value
    always_ff @(posedge aclk) begin
        if (ctl.load && sel) begin
            page_reg <= q_page;
        end
    end

    assign token_out     = token_reg;
    assign page_out      = page_reg;
    assign stat.match    = match;
    assign stat.sel      = sel;
    assign stat.valid    = valid_reg;
    assign stat.dirty    = dirty_reg;
    assign stat.cand_tok = token_reg && cand;

endmodule
